@@ sv/oil_paint_window_filter_assert.svh @@
// assertion macros for the oil paint window filter
`ifndef OIL_PAINT_WINDOW_FILTER_ASSERT_SVH
`define OIL_PAINT_WINDOW_FILTER_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define OPWF_ASSERT_IMP(lbl, pre, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (con)) else $error(msg);
`define OPWF_ASSERT_NXT(lbl, pre, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (con)) else $error(msg);
`else
`define OPWF_ASSERT_IMP(lbl, pre, con, msg)
`define OPWF_ASSERT_NXT(lbl, pre, con, msg)
`endif

`endif

@@ sv/opwf_pkg.sv @@
`default_nettype none
package opwf_pkg;

  localparam logic [1:0] CFG_LEVELS = 2'd0;
  localparam logic [1:0] CFG_RADIUS = 2'd1;
  localparam logic [1:0] CFG_WIDTH  = 2'd2;
  localparam logic [1:0] CFG_HEIGHT = 2'd3;

  localparam logic [8:0]  LEVELS_RST = 9'd8;
  localparam logic [2:0]  RADIUS_RST = 3'd2;
  localparam logic [10:0] WIDTH_RST  = 11'd640;
  localparam logic [15:0] HEIGHT_RST = 16'd480;

  localparam logic [13:0] YC_R   = 14'd4899;
  localparam logic [13:0] YC_G   = 14'd9617;
  localparam logic [13:0] YC_B   = 14'd1868;
  localparam logic [13:0] YC_RND = 14'd8192;

  typedef struct packed {
    logic accept;
    logic rd_center;
    logic hist_clr;
    logic win_rd;
    logic y_calc;
    logic q_calc;
    logic hist_upd;
    logic scan_step;
    logic div_start;
    logic div_step;
    logic load_out;
  } opwf_cmd_t;

  typedef struct packed {
    logic drop;
    logic early;
    logic pass_mode;
    logic win_last;
    logic scan_done;
    logic div_done;
    logic out_busy;
  } opwf_status_t;

endpackage
`default_nettype wire

@@ sv/opwf_ctrl.sv @@
`default_nettype none
module opwf_ctrl
  import opwf_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire opwf_status_t st,
  output opwf_cmd_t         cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_PASS = 4'd1;
  localparam logic [3:0] S_CLR  = 4'd2;
  localparam logic [3:0] S_ADDR = 4'd3;
  localparam logic [3:0] S_YC   = 4'd4;
  localparam logic [3:0] S_QC   = 4'd5;
  localparam logic [3:0] S_UPD  = 4'd6;
  localparam logic [3:0] S_SCAN = 4'd7;
  localparam logic [3:0] S_DST  = 4'd8;
  localparam logic [3:0] S_DIV  = 4'd9;
  localparam logic [3:0] S_OUT  = 4'd10;

  logic [3:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          if (st.drop || st.early) state_nxt = S_IDLE;
          else if (st.pass_mode) state_nxt = S_PASS;
          else state_nxt = S_CLR;
        end
      end
      S_PASS: begin
        cmd.rd_center = 1'b1;
        state_nxt = S_OUT;
      end
      S_CLR: begin
        cmd.hist_clr = 1'b1;
        state_nxt = S_ADDR;
      end
      S_ADDR: begin
        cmd.win_rd = 1'b1;
        state_nxt = S_YC;
      end
      S_YC: begin
        cmd.y_calc = 1'b1;
        state_nxt = S_QC;
      end
      S_QC: begin
        cmd.q_calc = 1'b1;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        cmd.hist_upd = 1'b1;
        state_nxt = st.win_last ? S_SCAN : S_ADDR;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (st.scan_done) state_nxt = S_DST;
      end
      S_DST: begin
        cmd.div_start = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (st.div_done) state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!st.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

@@ sv/opwf_dp.sv @@
`default_nettype none
module opwf_dp
  import opwf_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int RADIUS_MAX = 7,
  parameter int LEVEL_MAX  = 256
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         cfg_we,
  input  wire logic [1:0]   cfg_addr,
  input  wire logic [15:0]  cfg_wdata,
  input  wire logic [23:0]  in_tdata,
  input  wire logic         in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [23:0]       out_tdata,
  output logic              out_tlast,
  input  wire opwf_cmd_t    cmd,
  output opwf_status_t      st
);

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int WW   = CW + 1;
  localparam int LR   = 2 * RADIUS_MAX + 2;
  localparam int SW   = $clog2(LR);
  localparam int RW   = $clog2(RADIUS_MAX + 1) + 1;
  localparam int RU   = RW - 1;
  localparam int LW   = $clog2(LEVEL_MAX);
  localparam int LVW  = LW + 1;
  localparam int NWIN = (2 * RADIUS_MAX + 1) * (2 * RADIUS_MAX + 1);
  localparam int CNTW = $clog2(NWIN + 1);
  localparam int SUMW = 8 + CNTW;
  localparam int HW   = CNTW + 3 * SUMW;
  localparam int DCW  = $clog2(SUMW);
  localparam int AW   = SW + CW;
  localparam int DLW  = RU + WW + 1;
  localparam int ILW  = 17 + CW;

  logic [8:0]  levels_r;
  logic [2:0]  radius_r;
  logic [10:0] width_r;
  logic [15:0] height_r;

  logic [LVW-1:0] lv;
  logic [RU-1:0]  rad;
  logic [WW-1:0]  w;
  logic [15:0]    h;

  always_comb begin
    lv  = (int'(levels_r) > LEVEL_MAX) ? LVW'(LEVEL_MAX) : LVW'(levels_r);
    rad = (int'(radius_r) > RADIUS_MAX) ? RU'(RADIUS_MAX) : RU'(radius_r);
    if (width_r == 11'd0) w = WW'(1);
    else if (int'(width_r) > MAX_WIDTH) w = WW'(MAX_WIDTH);
    else w = WW'(width_r);
    h = (height_r == 16'd0) ? 16'd1 : height_r;
  end

  // frame positions
  logic [CW-1:0]  icol_r, ocol_r;
  logic [16:0]    irow_r;
  logic [15:0]    orow_r;
  logic [SW-1:0]  islot_r, oslot_r;
  logic [ILW-1:0] ilin_r;
  logic [DLW-1:0] dly;

  logic in_frame, last;
  assign in_frame = (irow_r < {1'b0, h});
  assign last     = (orow_r == h - 16'd1) && ({1'b0, ocol_r} == w - WW'(1));
  assign dly      = DLW'(rad) * DLW'(w) + DLW'(rad);

  assign st.drop      = in_frame && in_tuser;
  assign st.early     = (ilin_r < ILW'(dly));
  assign st.pass_mode = (lv == '0);

  // window walk
  logic signed [RW-1:0] dy_r, dx_r, rs;
  assign rs = $signed({1'b0, rad});
  assign st.win_last = (dx_r == rs) && (dy_r == rs);

  logic signed [CW+2:0] pc, wsig;
  logic signed [18:0]   pr, hsig, dif;
  logic signed [SW+1:0] ts, lrs;
  logic [CW-1:0]        wcol;
  logic [SW-1:0]        wslot;

  always_comb begin
    wsig = $signed({2'b00, w});
    pc = $signed({3'b000, ocol_r}) + (CW+3)'(dx_r);
    if (pc < 0) pc = -pc - (CW+3)'(1);
    if (pc >= wsig) pc = (wsig <<< 1) - (CW+3)'(1) - pc;
    if (pc < 0) pc = '0;
    if (pc >= wsig) pc = wsig - (CW+3)'(1);
    wcol = CW'(pc);
    hsig = $signed({3'b000, h});
    pr = $signed({3'b000, orow_r}) + 19'(dy_r);
    if (pr < 0) pr = -pr - 19'sd1;
    if (pr >= hsig) pr = (hsig <<< 1) - 19'sd1 - pr;
    if (pr < 0) pr = '0;
    if (pr >= hsig) pr = hsig - 19'sd1;
    dif = pr - $signed({3'b000, orow_r});
    lrs = $signed((SW+2)'(LR));
    ts = $signed({2'b00, oslot_r}) + (SW+2)'(dif);
    if (ts < 0) ts = ts + lrs;
    else if (ts >= lrs) ts = ts - lrs;
    wslot = SW'(ts);
  end

  // line store
  logic [23:0] store_mem [0:(1 << AW)-1];
  logic [23:0] px_r;
  logic [AW-1:0] rd_addr;
  assign rd_addr = cmd.rd_center ? {oslot_r, ocol_r} : {wslot, wcol};

  always_ff @(posedge clk) begin
    if (cmd.accept && !st.drop && in_frame) begin
      store_mem[{islot_r, icol_r}] <= in_tdata;
    end
    if (cmd.rd_center || cmd.win_rd) begin
      px_r <= store_mem[rd_addr];
    end
  end

  // gray level and quantization
  logic [22:0]      yacc;
  logic [7:0]       y_r;
  logic [8+LVW-1:0] prod;
  logic [LVW-1:0]   qq;
  logic [LW-1:0]    q, q_r;

  always_comb begin
    yacc = 23'(px_r[7:0]) * 23'(YC_R) + 23'(px_r[15:8]) * 23'(YC_G) +
           23'(px_r[23:16]) * 23'(YC_B) + 23'(YC_RND);
    prod = (8+LVW)'(y_r) * (8+LVW)'(lv);
    qq = LVW'(prod >> 8);
    if (qq >= lv) qq = lv - LVW'(1);
    q = LW'(qq);
  end

  // level histogram: count, red, green, blue sums
  logic [HW-1:0]  hist_mem [0:LEVEL_MAX-1];
  logic [LEVEL_MAX-1:0] hvld_r;
  logic [HW-1:0]  hrd_r, hold, hnew;
  logic           hvrd_r;
  logic [LVW-1:0] scan_i_r;
  logic [LW-1:0]  haddr;
  logic [CNTW-1:0] most_r;
  logic [SUMW-1:0] best_r [3];

  assign haddr = cmd.scan_step ? scan_i_r[LW-1:0] : q;
  assign st.scan_done = (scan_i_r == lv);

  always_comb begin
    hold = hvrd_r ? hrd_r : '0;
    hnew[HW-1 -: CNTW] = hold[HW-1 -: CNTW] + CNTW'(1);
    hnew[3*SUMW-1 -: SUMW] = hold[3*SUMW-1 -: SUMW] + SUMW'(px_r[7:0]);
    hnew[2*SUMW-1 -: SUMW] = hold[2*SUMW-1 -: SUMW] + SUMW'(px_r[15:8]);
    hnew[SUMW-1:0] = hold[SUMW-1:0] + SUMW'(px_r[23:16]);
  end

  always_ff @(posedge clk) begin
    if (cmd.q_calc || cmd.scan_step) begin
      hrd_r <= hist_mem[haddr];
    end
    if (cmd.hist_upd) begin
      hist_mem[q_r] <= hnew;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hvld_r <= '0;
    end else if (cmd.hist_clr) begin
      hvld_r <= '0;
    end else if (cmd.hist_upd) begin
      hvld_r[q_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.q_calc || cmd.scan_step) hvrd_r <= hvld_r[haddr];
    if (cmd.y_calc) y_r <= yacc[21:14];
    if (cmd.q_calc) q_r <= q;
  end

  // window counters and mode search
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dy_r <= '0;
      dx_r <= '0;
      scan_i_r <= '0;
      most_r <= '0;
    end else if (cmd.hist_clr) begin
      dy_r <= -rs;
      dx_r <= -rs;
      scan_i_r <= '0;
      most_r <= '0;
    end else begin
      if (cmd.hist_upd) begin
        if (dx_r == rs) begin
          dx_r <= -rs;
          dy_r <= dy_r + RW'(1);
        end else begin
          dx_r <= dx_r + RW'(1);
        end
      end
      if (cmd.scan_step) begin
        scan_i_r <= scan_i_r + LVW'(1);
        if (scan_i_r != '0 && hvrd_r && hrd_r[HW-1 -: CNTW] > most_r) begin
          most_r <= hrd_r[HW-1 -: CNTW];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_step && scan_i_r != '0 && hvrd_r && hrd_r[HW-1 -: CNTW] > most_r) begin
      best_r[0] <= hrd_r[3*SUMW-1 -: SUMW];
      best_r[1] <= hrd_r[2*SUMW-1 -: SUMW];
      best_r[2] <= hrd_r[SUMW-1:0];
    end
  end

  // three-lane restoring divider, one quotient bit per cycle
  logic [CNTW-1:0] rem_r [3];
  logic [SUMW-1:0] dq_r  [3];
  logic [DCW-1:0]  dcnt_r;
  logic [CNTW:0]   dt    [3];
  logic            dge   [3];

  assign st.div_done = (dcnt_r == DCW'(SUMW - 1));

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      dt[l]  = {rem_r[l], dq_r[l][SUMW-1]};
      dge[l] = (dt[l] >= {1'b0, most_r});
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dcnt_r <= '0;
      for (int l = 0; l < 3; l++) begin
        rem_r[l] <= '0;
        dq_r[l]  <= best_r[l];
      end
    end else if (cmd.div_step) begin
      dcnt_r <= dcnt_r + DCW'(1);
      for (int l = 0; l < 3; l++) begin
        rem_r[l] <= dge[l] ? CNTW'(dt[l] - {1'b0, most_r}) : CNTW'(dt[l]);
        dq_r[l]  <= {dq_r[l][SUMW-2:0], dge[l]};
      end
    end
  end

  // output register
  logic out_valid_r;
  assign out_tvalid  = out_valid_r;
  assign st.out_busy = out_valid_r && !out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_tdata <= st.pass_mode ? px_r : {dq_r[2][7:0], dq_r[1][7:0], dq_r[0][7:0]};
      out_tlast <= last;
    end
  end

  // positions and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      levels_r <= LEVELS_RST;
      radius_r <= RADIUS_RST;
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
      icol_r <= '0;
      irow_r <= '0;
      islot_r <= '0;
      ilin_r <= '0;
      ocol_r <= '0;
      orow_r <= '0;
      oslot_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_LEVELS: levels_r <= cfg_wdata[8:0];
        CFG_RADIUS: radius_r <= cfg_wdata[2:0];
        CFG_WIDTH:  width_r  <= cfg_wdata[10:0];
        CFG_HEIGHT: height_r <= cfg_wdata;
        default:    levels_r <= levels_r;
      endcase
      icol_r <= '0;
      irow_r <= '0;
      islot_r <= '0;
      ilin_r <= '0;
      ocol_r <= '0;
      orow_r <= '0;
      oslot_r <= '0;
    end else begin
      if (cmd.accept && !st.drop) begin
        ilin_r <= ilin_r + ILW'(1);
        if ({1'b0, icol_r} + WW'(1) >= w) begin
          icol_r <= '0;
          irow_r <= irow_r + 17'd1;
          islot_r <= (int'(islot_r) == LR - 1) ? '0 : islot_r + SW'(1);
        end else begin
          icol_r <= icol_r + CW'(1);
        end
      end
      if (cmd.load_out) begin
        if (last) begin
          icol_r <= '0;
          irow_r <= '0;
          islot_r <= '0;
          ilin_r <= '0;
          ocol_r <= '0;
          orow_r <= '0;
          oslot_r <= '0;
        end else if ({1'b0, ocol_r} + WW'(1) >= w) begin
          ocol_r <= '0;
          orow_r <= orow_r + 16'd1;
          oslot_r <= (int'(oslot_r) == LR - 1) ? '0 : oslot_r + SW'(1);
        end else begin
          ocol_r <= ocol_r + CW'(1);
        end
      end
    end
  end

endmodule
`default_nettype wire

@@ sv/oil_paint_window_filter.sv @@
`default_nettype none
// Oil paint filter over RGB pixels in raster order. Each result is the mean color of the
// most frequent gray level in a mirrored square window; results trail input by
// radius*width+radius transfers and pad transfers (tuser high) flush the frame tail.
// One item at a time: a painted pixel takes each window pixel through address, gray
// level, quantization and histogram update states (for the single line store read port
// and the histogram read-modify-write), then scans the levels for the mode and runs the
// divider; pass-through reads only the center pixel. Items with no result stay idle.
// The histogram is cleared by valid bits; the line store is never cleared. Configuration
// must be written only while idle (not enforced here); a write restarts the frame.
module oil_paint_window_filter
  import opwf_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int RADIUS_MAX = 7,
  parameter int LEVEL_MAX  = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_addr,
  input  wire logic [15:0] cfg_wdata,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // in_red, in_green, in_blue
  input  wire logic        in_tuser,   // pad
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // out_red, out_green, out_blue
  output logic             out_tlast
);

  opwf_cmd_t    cmd;
  opwf_status_t st;

  opwf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  opwf_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .RADIUS_MAX (RADIUS_MAX),
    .LEVEL_MAX  (LEVEL_MAX)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cmd        (cmd),
    .st         (st)
  );

`include "oil_paint_window_filter_assert.svh"

  `OPWF_ASSERT_IMP(a_load_free, cmd.load_out, !st.out_busy, "result loaded over a waiting one")
  `OPWF_ASSERT_NXT(a_no_instant_out, in_tvalid && in_tready, !cmd.load_out, "result without work")
  `OPWF_ASSERT_NXT(a_upd_busy, cmd.hist_upd, !in_tready, "input taken during window walk")

endmodule
`default_nettype wire
